>>> hw/rtl/ambs_pkg.sv
// ---------------------------------------------------------------------------
// ambs_pkg: shared types and constants
// Channel lane results, queued results and register and action codes for the
// approximate-median background subtraction core.
// ---------------------------------------------------------------------------
`default_nettype none

package ambs_pkg;

    localparam int unsigned NUM_CH    = 3;
    localparam int unsigned CH_W      = 8;
    localparam int unsigned WORD_W    = NUM_CH * CH_W;
    localparam int unsigned IDX_W     = 17;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    // Result queue geometry.
    localparam int unsigned OQ_DEPTH = 4;
    localparam int unsigned OQ_AW    = 2;
    localparam int unsigned OQ_CW    = OQ_AW + 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLING_RATE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_FRAMES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT   = 3'd4;

    // Action codes of an input request.
    localparam logic ACT_CLASSIFY = 1'b0;
    localparam logic ACT_UPDATE   = 1'b1;

    // Channel count value that selects all three channels.
    localparam logic [1:0] CH_COUNT_ALL = 2'd3;

    // Phase value on which background updates are made.
    localparam logic [7:0] UPDATE_PHASE = 8'd1;

    typedef struct packed {
        logic            low_ok;
        logic            high_ok;
        logic [CH_W-1:0] nudged;
    } lane_res_t;

    typedef struct packed {
        logic low_fg;
        logic high_fg;
    } res_t;

    typedef struct packed {
        res_t              res;
        logic [WORD_W-1:0] nudged_word;
    } merge_t;

endpackage

`default_nettype wire

>>> hw/rtl/adaptive_median_background_subtract_core.sv
// ---------------------------------------------------------------------------
// adaptive_median_background_subtract_core: per-pixel background subtractor
// Approximate-median background model with low and high limit masks, three
// channel lanes, a background memory and a result queue.
// ---------------------------------------------------------------------------
`default_nettype none

// This core accepts one pixel request per clock cycle while the result queue
// has room, for any mix of classify and update requests, including repeated
// requests to the same pixel. A request is read from the background memory
// at acceptance, judged and written back in the following cycle, and a
// classify result is pushed into the result queue as it is judged. The
// background memory has a single registered read port; a forwarding
// register covers a request that reads a pixel whose new value is being
// written at the same edge. Results wait in a four-entry queue, and in_ready
// drops only when that queue, together with a result still in flight, would
// otherwise overflow, so a consumer that takes one result per cycle never
// slows the input. The background memory is not cleared: every pixel must
// be classified during the first frame before it is used in later frames.
// Configuration writes are always accepted and must only be issued while no
// request is in flight.
module adaptive_median_background_subtract_core #(
    parameter int unsigned MAX_PIXELS = 131072
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    // Configuration write channel.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ambs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ambs_pkg::CFG_DAT_W-1:0]    cfg_data,

    // Pixel request channel.
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              action,
    input  wire logic [ambs_pkg::IDX_W-1:0]        pixel_index,
    input  wire logic [ambs_pkg::CH_W-1:0]         sample_ch0,
    input  wire logic [ambs_pkg::CH_W-1:0]         sample_ch1,
    input  wire logic [ambs_pkg::CH_W-1:0]         sample_ch2,
    input  wire logic                              mask_background,
    input  wire logic                              end_of_frame,

    // Classification result channel.
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   low_foreground,
    output logic                                   high_foreground
);

    localparam int unsigned CH_W   = ambs_pkg::CH_W;
    localparam int unsigned WORD_W = ambs_pkg::WORD_W;
    localparam int unsigned AW     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int unsigned EW     = (AW > ambs_pkg::IDX_W) ? AW : ambs_pkg::IDX_W;
    localparam int unsigned CW     = EW + 1;

    // Configuration registers.
    logic [CH_W-1:0]  low_limit_reg;
    logic [CH_W-1:0]  high_limit_reg;
    logic [CH_W-1:0]  sampling_rate_reg;
    logic [15:0]      learning_frames_reg;
    logic [1:0]       channel_count_reg;

    // Frame state.
    logic [15:0]      frames_seen_reg;
    logic [15:0]      frames_seen_next;
    logic [CH_W-1:0]  sample_phase_reg;
    logic [CH_W-1:0]  sample_phase_next;
    logic [CH_W:0]    phase_inc;

    // Acceptance and address decode.
    logic             in_fire;
    logic [EW-1:0]    idx_ext;
    logic             in_range;
    logic [AW-1:0]    rd_addr;

    // Second stage: the request whose background word is being read.
    logic             s1_valid_reg;
    logic             s1_action_reg;
    logic [AW-1:0]    s1_addr_reg;
    logic             s1_in_range_reg;
    logic [WORD_W-1:0] s1_pix_reg;
    logic             s1_mask_reg;
    logic             s1_eof_reg;

    // Background memory and its write forwarding.
    logic [WORD_W-1:0] bg_mem [MAX_PIXELS];
    logic [WORD_W-1:0] mem_q_reg;
    logic              fwd_valid_reg;
    logic [AW-1:0]     fwd_addr_reg;
    logic [WORD_W-1:0] fwd_data_reg;
    logic              mem_we;
    logic [WORD_W-1:0] wr_data;

    // Datapath of the second stage.
    logic              first_frame;
    logic              learning;
    logic              is_classify;
    logic [WORD_W-1:0] stored_word;
    logic [WORD_W-1:0] bg_word;
    logic              store_en;
    logic              update_en;
    logic              push;
    logic              frame_done;
    logic [CH_W-1:0]   pix_ch [ambs_pkg::NUM_CH];
    logic [CH_W-1:0]   bg_ch  [ambs_pkg::NUM_CH];
    ambs_pkg::lane_res_t lane_res [ambs_pkg::NUM_CH];
    ambs_pkg::merge_t  merged;

    // Result queue.
    ambs_pkg::res_t              oq_head;
    logic                        oq_not_empty;
    logic [ambs_pkg::OQ_CW-1:0]  oq_count;
    logic [ambs_pkg::OQ_CW-1:0]  oq_committed;

    assign cfg_ready = 1'b1;

    // A request may enter only when the queue can hold its result along with
    // the result of the request now in the second stage.
    assign oq_committed = oq_count + ambs_pkg::OQ_CW'(push);
    assign in_ready     = oq_committed < ambs_pkg::OQ_CW'(ambs_pkg::OQ_DEPTH);
    assign in_fire      = in_valid && in_ready;

    assign idx_ext  = EW'(pixel_index);
    assign in_range = {1'b0, idx_ext} < CW'(MAX_PIXELS);
    assign rd_addr  = idx_ext[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_limit_reg       <= 8'd20;
            high_limit_reg      <= 8'd40;
            sampling_rate_reg   <= 8'd7;
            learning_frames_reg <= 16'd30;
            channel_count_reg   <= 2'd3;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ambs_pkg::CFG_LOW_LIMIT:       low_limit_reg       <= cfg_data[CH_W-1:0];
                ambs_pkg::CFG_HIGH_LIMIT:      high_limit_reg      <= cfg_data[CH_W-1:0];
                ambs_pkg::CFG_SAMPLING_RATE:   sampling_rate_reg   <= cfg_data[CH_W-1:0];
                ambs_pkg::CFG_LEARNING_FRAMES: learning_frames_reg <= cfg_data;
                ambs_pkg::CFG_CHANNEL_COUNT:   channel_count_reg   <= cfg_data[1:0];
                default:
                begin
                end
            endcase
        end
    end

    // First stage: capture the request and start the memory read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_action_reg   <= action;
            s1_addr_reg     <= rd_addr;
            s1_in_range_reg <= in_range;
            s1_pix_reg      <= {sample_ch2, sample_ch1, sample_ch0};
            s1_mask_reg     <= mask_background;
            s1_eof_reg      <= end_of_frame;
        end
    end

    // The memory returns the old word when it is written at the same edge,
    // so the word written at that edge is kept in a register to forward.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mem_q_reg <= bg_mem[rd_addr];
        end
        if (mem_we)
        begin
            bg_mem[s1_addr_reg] <= wr_data;
        end
        fwd_addr_reg <= s1_addr_reg;
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= mem_we;
        end
    end

    // Second stage: judge against the background and write it back.
    assign first_frame = frames_seen_reg == '0;
    assign learning    = frames_seen_reg < learning_frames_reg;
    assign is_classify = s1_action_reg == ambs_pkg::ACT_CLASSIFY;

    assign stored_word = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg
                                                                           : mem_q_reg;

    always_comb
    begin
        priority if (is_classify && first_frame)
        begin
            bg_word = s1_pix_reg;
        end
        else if (s1_in_range_reg)
        begin
            bg_word = stored_word;
        end
        else
        begin
            bg_word = '0;
        end
    end

    for (genvar g = 0; g < ambs_pkg::NUM_CH; g++)
    begin : g_lane
        assign pix_ch[g] = s1_pix_reg[g*CH_W +: CH_W];
        assign bg_ch[g]  = bg_word[g*CH_W +: CH_W];

        ambs_lane u_lane (
            .pix        (pix_ch[g]),
            .bg         (bg_ch[g]),
            .low_limit  (low_limit_reg),
            .high_limit (high_limit_reg),
            .res        (lane_res[g])
        );
    end

    ambs_merge u_merge (
        .lanes   (lane_res),
        .bg_word (bg_word),
        .use_all (channel_count_reg == ambs_pkg::CH_COUNT_ALL),
        .merged  (merged)
    );

    // In the first frame each in-range classify stores the pixel whole; later
    // sampling-phase updates when masked or learning step the background.
    assign store_en  = s1_valid_reg && is_classify && first_frame && s1_in_range_reg;
    assign update_en = s1_valid_reg && !is_classify && s1_in_range_reg &&
                       (sample_phase_reg == ambs_pkg::UPDATE_PHASE) &&
                       (s1_mask_reg || learning);
    assign mem_we    = store_en || update_en;
    assign wr_data   = store_en ? s1_pix_reg : merged.nudged_word;

    assign push       = s1_valid_reg && is_classify;
    assign frame_done = push && s1_eof_reg;

    // The phase wraps to zero when it would reach the sampling rate, so a
    // rate of zero or one keeps it at zero and no update is ever made.
    assign phase_inc = {1'b0, sample_phase_reg} + (CH_W + 1)'(1);

    always_comb
    begin
        frames_seen_next  = frames_seen_reg;
        sample_phase_next = sample_phase_reg;
        if (frame_done)
        begin
            if (frames_seen_reg != 16'hFFFF)
            begin
                frames_seen_next = frames_seen_reg + 16'd1;
            end
            if (phase_inc >= {1'b0, sampling_rate_reg})
            begin
                sample_phase_next = '0;
            end
            else
            begin
                sample_phase_next = phase_inc[CH_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_seen_reg  <= '0;
            sample_phase_reg <= '0;
        end
        else
        begin
            frames_seen_reg  <= frames_seen_next;
            sample_phase_reg <= sample_phase_next;
        end
    end

    ambs_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (merged.res),
        .pop       (out_ready),
        .head      (oq_head),
        .not_empty (oq_not_empty),
        .count     (oq_count)
    );

    assign out_valid       = oq_not_empty;
    assign low_foreground  = oq_head.low_fg;
    assign high_foreground = oq_head.high_fg;

`ifndef NO_ASSERTIONS
    // The queue is never pushed while it is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (oq_count < ambs_pkg::OQ_CW'(ambs_pkg::OQ_DEPTH)))
        else $error("result queue overflow");

    // The frame count never moves backward.
    assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (frames_seen_reg >= $past(frames_seen_reg)))
        else $error("frame count decreased");

    // A first-frame classify compares the pixel with itself.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && first_frame) |-> (!merged.res.low_fg && !merged.res.high_fg))
        else $error("first frame classify reported foreground");

    // Only an update or a first-frame classify writes the background.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (s1_valid_reg && (!is_classify || first_frame)))
        else $error("unexpected background write");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/ambs_lane.sv
// ---------------------------------------------------------------------------
// ambs_lane: one color channel lane
// Compares a channel against its background value for both limits and forms
// the background value moved one step toward the sample.
// ---------------------------------------------------------------------------
`default_nettype none

module ambs_lane (
    input  wire logic [ambs_pkg::CH_W-1:0] pix,
    input  wire logic [ambs_pkg::CH_W-1:0] bg,
    input  wire logic [ambs_pkg::CH_W-1:0] low_limit,
    input  wire logic [ambs_pkg::CH_W-1:0] high_limit,
    output ambs_pkg::lane_res_t            res
);

    logic [ambs_pkg::CH_W-1:0] diff;
    logic                      pix_above;
    logic                      pix_below;

    assign pix_above = pix > bg;
    assign pix_below = pix < bg;
    assign diff      = pix_above ? (pix - bg) : (bg - pix);

    always_comb
    begin
        res.low_ok  = diff <= low_limit;
        res.high_ok = diff <= high_limit;
        priority if (pix_above)
        begin
            res.nudged = bg + ambs_pkg::CH_W'(1);
        end
        else if (pix_below)
        begin
            res.nudged = bg - ambs_pkg::CH_W'(1);
        end
        else
        begin
            res.nudged = bg;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ambs_merge.sv
// ---------------------------------------------------------------------------
// ambs_merge: lane merging stage
// Combines the per-channel verdicts into the two foreground flags and
// assembles the nudged background word, keeping unused channels unchanged.
// ---------------------------------------------------------------------------
`default_nettype none

module ambs_merge (
    input  wire ambs_pkg::lane_res_t           lanes [ambs_pkg::NUM_CH],
    input  wire logic [ambs_pkg::WORD_W-1:0]   bg_word,
    input  wire logic                          use_all,
    output ambs_pkg::merge_t                   merged
);

    always_comb
    begin
        merged.res.low_fg  = !lanes[0].low_ok;
        merged.res.high_fg = !lanes[0].high_ok;
        merged.nudged_word = bg_word;
        merged.nudged_word[ambs_pkg::CH_W-1:0] = lanes[0].nudged;
        if (use_all)
        begin
            for (int k = 1; k < ambs_pkg::NUM_CH; k++)
            begin
                if (!lanes[k].low_ok)
                begin
                    merged.res.low_fg = 1'b1;
                end
                if (!lanes[k].high_ok)
                begin
                    merged.res.high_fg = 1'b1;
                end
                merged.nudged_word[k*ambs_pkg::CH_W +: ambs_pkg::CH_W] = lanes[k].nudged;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ambs_out_fifo.sv
// ---------------------------------------------------------------------------
// ambs_out_fifo: result queue
// A small queue that holds classification results until the consumer takes
// them, so the pipeline never has to stall mid-flight.
// ---------------------------------------------------------------------------
`default_nettype none

module ambs_out_fifo (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire ambs_pkg::res_t               push_data,
    input  wire logic                         pop,
    output ambs_pkg::res_t                    head,
    output logic                              not_empty,
    output logic [ambs_pkg::OQ_CW-1:0]        count
);

    ambs_pkg::res_t                  entry_reg [ambs_pkg::OQ_DEPTH];
    logic [ambs_pkg::OQ_AW-1:0]      wr_ptr_reg;
    logic [ambs_pkg::OQ_AW-1:0]      rd_ptr_reg;
    logic [ambs_pkg::OQ_CW-1:0]      count_reg;
    logic [ambs_pkg::OQ_CW-1:0]      count_next;
    logic                            do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign count     = count_reg;

    always_comb
    begin
        count_next = count_reg;
        unique case ({push, do_pop})
            2'b10:   count_next = count_reg + ambs_pkg::OQ_CW'(1);
            2'b01:   count_next = count_reg - ambs_pkg::OQ_CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + ambs_pkg::OQ_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + ambs_pkg::OQ_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire
